// ===== design/tlr_pkg.sv =====
// Shared types and constants of the table id LRU registry.
package tlr_pkg;

  localparam int unsigned ReqTypeW       = 2;
  localparam int unsigned IdW            = 48;
  localparam int unsigned TagW           = 32;
  localparam int unsigned DefaultEntries = 64;
  localparam int unsigned DefaultSlotW   = $clog2(DefaultEntries);
  localparam int unsigned DefaultOccW    = $clog2(DefaultEntries + 1);

  typedef enum logic [ReqTypeW-1:0] {
    ReqMap    = 2'd0,
    ReqLookup = 2'd1,
    ReqClear  = 2'd2
  } req_type_e;

endpackage

// ===== design/tlr_req_if.sv =====
// Request channel of the table id LRU registry.
interface tlr_req_if;
  logic                          valid;
  logic                          ready;
  logic [tlr_pkg::ReqTypeW-1:0]  req_type;
  logic [tlr_pkg::IdW-1:0]       tbl_id;
  logic [tlr_pkg::TagW-1:0]      body_tag;
  logic                          parse_ok;

  modport source (output valid, req_type, tbl_id, body_tag, parse_ok, input ready);
  modport sink   (input valid, req_type, tbl_id, body_tag, parse_ok, output ready);
endinterface

// ===== design/tlr_rsp_if.sv =====
// Response channel of the table id LRU registry.
interface tlr_rsp_if #(
  parameter int unsigned SlotW = tlr_pkg::DefaultSlotW,
  parameter int unsigned OccW  = tlr_pkg::DefaultOccW
);
  logic                     valid;
  logic                     ready;
  logic                     done_ok;
  logic                     unchanged;
  logic [SlotW-1:0]         slot;
  logic                     evicted_valid;
  logic [tlr_pkg::IdW-1:0]  evicted_id;
  logic [OccW-1:0]          occupancy;

  modport source (output valid, done_ok, unchanged, slot, evicted_valid, evicted_id,
                  occupancy, input ready);
  modport sink   (input valid, done_ok, unchanged, slot, evicted_valid, evicted_id,
                  occupancy, output ready);
endinterface

// ===== design/table_id_lru_registry_top.sv =====
// Top level: fully associative table id store with LRU replacement.
//
//  channel | dir | handshake     | payload
//  req_i   | in  | valid / ready | req_type, tbl_id, body_tag, parse_ok
//  rsp_o   | out | valid / ready | done_ok, unchanged, slot, evicted_valid,
//          |     |               | evicted_id, occupancy
//
// Map and lookup walk the key/tag/age memories once (one read port); a touch or
// insert walks the age memory again. Clear and unknown requests skip both walks
// and go straight to the result; the next request can be taken in the cycle after
// the result is loaded into the output register.
// Valid bits and occupancy clear on reset. req_i.ready is high only while idle; a
// result waits in the output register and blocks only the next result.
module table_id_lru_registry_top #(
  parameter int unsigned ENTRIES = tlr_pkg::DefaultEntries
) (
  input logic       clk_i,
  input logic       rst_ni,
  tlr_req_if.sink   req_i,
  tlr_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = tlr_pkg::IdW;
  localparam int unsigned TW = tlr_pkg::TagW;
  localparam logic [CW-1:0] CntMax = CW'(ENTRIES);
  localparam logic [AW-1:0] AgeOld = AW'(ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic prv_vld_q;
  logic [AW-1:0] prv_idx_q;
  logic out_vld_q, out_vld_d;

  // request fields
  tlr_pkg::req_type_e req_q;
  logic [IW-1:0] id_q;
  logic [TW-1:0] tag_q;
  logic pok_q;

  // memories
  logic [IW-1:0] key_mem [ENTRIES];
  logic [TW-1:0] tag_mem [ENTRIES];
  logic [AW-1:0] age_mem [ENTRIES];
  logic [IW-1:0] rd_key_q;
  logic [TW-1:0] rd_tag_q;
  logic [AW-1:0] rd_age_q;
  logic [AW-1:0] rd_addr;

  // scan results
  logic hit_q, hit_teq_q, free_q;
  logic [AW-1:0] hit_slot_q, hit_age_q, free_slot_q, ev_slot_q;
  logic [IW-1:0] ev_key_q;

  // update pass
  logic upd_ins_q;
  logic [AW-1:0] upd_slot_q, upd_age_q;
  logic age_we;
  logic [AW-1:0] age_wd;

  // pending result
  logic res_ok_q, res_unch_q, res_ev_q;
  logic [AW-1:0] res_slot_q;
  logic [IW-1:0] res_evid_q;

  // output register
  logic out_ok_q, out_unch_q, out_ev_q;
  logic [AW-1:0] out_slot_q;
  logic [IW-1:0] out_evid_q;
  logic [CW-1:0] out_occ_q;

  // decision
  logic dec_ok, dec_unch, dec_ev, dec_touch, dec_ins, dec_new, dec_tagw, dec_inc;
  logic [AW-1:0] dec_slot;

  logic accept, load_out, walk_end, ent_valid;

  assign accept    = req_i.valid && (state_q == ST_IDLE);
  assign load_out  = (state_q == ST_FIN) && (!out_vld_q || rsp_o.ready);
  assign walk_end  = (idx_q == CntMax);
  assign rd_addr   = (idx_q < CntMax) ? idx_q[AW-1:0] : '0;
  assign ent_valid = valid_q[prv_idx_q];

  always_comb begin
    dec_ok    = 1'b0;
    dec_unch  = 1'b0;
    dec_ev    = 1'b0;
    dec_touch = 1'b0;
    dec_ins   = 1'b0;
    dec_new   = 1'b0;
    dec_tagw  = 1'b0;
    dec_inc   = 1'b0;
    dec_slot  = hit_slot_q;
    unique case (req_q)
      tlr_pkg::ReqMap: begin
        if (hit_q && hit_teq_q) begin
          dec_ok    = 1'b1;
          dec_unch  = 1'b1;
          dec_touch = 1'b1;
        end else if (pok_q) begin
          dec_ok    = 1'b1;
          dec_touch = 1'b1;
          dec_tagw  = 1'b1;
          if (!hit_q) begin
            dec_ins = 1'b1;
            dec_new = 1'b1;
            if (count_q == CntMax) begin
              dec_ev   = 1'b1;
              dec_slot = ev_slot_q;
            end else begin
              dec_slot = free_slot_q;
              dec_inc  = 1'b1;
            end
          end
        end
      end
      tlr_pkg::ReqLookup: begin
        if (hit_q) begin
          dec_ok    = 1'b1;
          dec_touch = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // age rewrite: touched/inserted slot goes to 0, younger (or all) valid ones age
  always_comb begin
    if (prv_idx_q == upd_slot_q) begin
      age_wd = '0;
    end else if (ent_valid && (upd_ins_q || rd_age_q < upd_age_q)) begin
      age_wd = AW'(rd_age_q + 1'b1);
    end else begin
      age_wd = rd_age_q;
    end
  end
  assign age_we = (state_q == ST_UPDATE) && prv_vld_q;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    valid_d   = valid_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          unique case (tlr_pkg::req_type_e'(req_i.req_type)) inside
            tlr_pkg::ReqMap, tlr_pkg::ReqLookup: state_d = ST_SCAN;
            tlr_pkg::ReqClear: begin
              valid_d = '0;
              count_d = '0;
              state_d = ST_FIN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        idx_d = CW'(idx_q + 1'b1);
        if (walk_end) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        idx_d = '0;
        if (dec_new) valid_d[dec_slot] = 1'b1;
        if (dec_inc) count_d = CW'(count_q + 1'b1);
        state_d = dec_touch ? ST_UPDATE : ST_FIN;
      end
      ST_UPDATE: begin
        idx_d = CW'(idx_q + 1'b1);
        if (walk_end) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      count_q   <= '0;
      valid_q   <= '0;
      prv_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
      valid_q   <= valid_d;
      prv_vld_q <= ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (idx_q < CntMax);
      out_vld_q <= out_vld_d;
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DECIDE) && dec_new) key_mem[dec_slot] <= id_q;
    rd_key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DECIDE) && dec_tagw) tag_mem[dec_slot] <= tag_q;
    rd_tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (age_we) age_mem[prv_idx_q] <= age_wd;
    rd_age_q <= age_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    prv_idx_q <= rd_addr;
    if (accept) begin
      req_q      <= tlr_pkg::req_type_e'(req_i.req_type);
      id_q       <= req_i.tbl_id;
      tag_q      <= req_i.body_tag;
      pok_q      <= req_i.parse_ok;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      res_ok_q   <= (tlr_pkg::req_type_e'(req_i.req_type) == tlr_pkg::ReqClear);
      res_unch_q <= 1'b0;
      res_ev_q   <= 1'b0;
      res_slot_q <= '0;
      res_evid_q <= '0;
    end
    if ((state_q == ST_SCAN) && prv_vld_q) begin
      if (ent_valid && !hit_q && (rd_key_q == id_q)) begin
        hit_q      <= 1'b1;
        hit_slot_q <= prv_idx_q;
        hit_teq_q  <= (rd_tag_q == tag_q);
        hit_age_q  <= rd_age_q;
      end
      if (!ent_valid && !free_q) begin
        free_q      <= 1'b1;
        free_slot_q <= prv_idx_q;
      end
      // oldest entry, only consulted when the store is full
      if (ent_valid && (rd_age_q == AgeOld)) begin
        ev_slot_q <= prv_idx_q;
        ev_key_q  <= rd_key_q;
      end
    end
    if (state_q == ST_DECIDE) begin
      upd_ins_q  <= dec_ins;
      upd_slot_q <= dec_slot;
      upd_age_q  <= hit_age_q;
      res_ok_q   <= dec_ok;
      res_unch_q <= dec_unch;
      res_ev_q   <= dec_ev;
      res_slot_q <= dec_ok ? dec_slot : '0;
      res_evid_q <= dec_ev ? ev_key_q : '0;
    end
    if (load_out) begin
      out_ok_q   <= res_ok_q;
      out_unch_q <= res_unch_q;
      out_ev_q   <= res_ev_q;
      out_slot_q <= res_slot_q;
      out_evid_q <= res_evid_q;
      out_occ_q  <= count_q;
    end
  end

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.done_ok       = out_ok_q;
  assign rsp_o.unchanged     = out_unch_q;
  assign rsp_o.slot          = out_slot_q;
  assign rsp_o.evicted_valid = out_ev_q;
  assign rsp_o.evicted_id    = out_evid_q;
  assign rsp_o.occupancy     = out_occ_q;

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CW'($countones(valid_q)))
    else $error("occupancy count differs from number of valid entries");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("occupancy count above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type == tlr_pkg::ReqClear)) |=> (count_q == '0) && (valid_q == '0))
    else $error("clear left entries valid");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.evicted_valid) |-> (rsp_o.occupancy == CntMax))
    else $error("eviction reported while store not full");

endmodule
